### hw/rtl/cht_pkg.sv
// Package for the chained hash table: transaction structs, codes, sequencer states.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none
package cht_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_FIND     = 2'd0;
    localparam logic [1:0] FUNC_ADD      = 2'd1;
    localparam logic [1:0] FUNC_ADD_EXCL = 2'd2;
    localparam logic [1:0] FUNC_DELETE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [7:0]  handle;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] entry_handle;
        logic       prev_valid;
        logic [7:0] prev_handle;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_WALK,
        S_UPDATE,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                    aclk,
    input  wire                                    we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                       wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/chained_hash_table_top.sv
// Chained hash table: bucket select by iterative modulo, chain walk over slot RAM.
// Depends on cht_pkg and cht_ram.
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+----------------------
//  request | s_valid  s_ready  s_data       | in        | req_t (func,key,handle)
//  result  | m_valid  m_ready  m_data       | out       | rsp_t
//  config  | cfg_valid cfg_ready cfg_data   | in        | bucket_count, 9 bits
//
// One transaction runs a bit-serial remainder over the key bits in the
// subtract/compare unit, one head RAM read, a walk of the chain slot by slot
// through the registered slot RAM read, an update step and a result step.
// After reset a clearing pass writes every bucket head empty, with s_ready
// low. A stalled result holds the block in the result state until m_ready;
// config is always ready.
`default_nettype none
module chained_hash_table_top
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = 256,
    parameter int ENTRY_COUNT = 256,
    parameter int KEY_BITS    = 32
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  wire              m_ready,
    output rsp_t             m_data,
    input  wire              cfg_valid,
    output logic             cfg_ready,
    input  wire  [CFG_W-1:0] cfg_data
);

    localparam int KEY_W  = (KEY_BITS > 32) ? 32 : KEY_BITS;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOT_W = $clog2(ENTRY_COUNT);
    localparam int DIV_W  = $clog2(NUM_BUCKETS + 1);
    localparam int CNT_W  = $clog2(KEY_W + 1);
    localparam int STEP_W = SLOT_W + 1;
    localparam int HEAD_W = SLOT_W + 1;
    localparam int SRAM_W = KEY_W + HEAD_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [BKT_W-1:0]  bkt_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [DIV_W-1:0]  div_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [HEAD_W-1:0] link_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] bcount_reg;
    logic [1:0]  func_reg;
    key_t        key_reg;
    logic [7:0]  handle_reg;
    key_t        quo_reg, quo_next;
    div_t        rem_reg, rem_next;
    div_t        div_reg, div_next;
    cnt_t        cnt_reg, cnt_next;
    bkt_t        bkt_reg, bkt_next;
    bkt_t        clr_reg, clr_next;
    link_t       head_reg, head_next;
    slot_t       cur_reg, cur_next;
    step_t       step_reg, step_next;
    logic        found_reg, found_next;
    slot_t       match_reg, match_next;
    link_t       mnext_reg, mnext_next;
    logic        pvalid_reg, pvalid_next;
    slot_t       prev_reg, prev_next;
    key_t        pkey_reg, pkey_next;
    rsp_t        res_reg, res_next;
    logic        m_valid_reg, m_valid_next;
    rsp_t        m_data_reg;

    // RAM ports
    logic        hd_we;
    bkt_t        hd_waddr;
    link_t       hd_wdata, hd_rdata;
    logic        sl_we;
    slot_t       sl_waddr, sl_raddr;
    logic [SRAM_W-1:0] sl_wdata, sl_rdata;

    // Datapath helper values
    logic [31:0]       clamp;
    logic [DIV_W:0]    trial;
    logic              s_fire;
    key_t              sl_key;
    link_t             sl_link;
    logic              add_op, add_ok, skip_dup;
    step_t             step_inc;

    assign s_fire   = s_valid && s_ready;
    assign sl_key   = sl_rdata[SRAM_W-1 -: KEY_W];
    assign sl_link  = sl_rdata[HEAD_W-1:0];
    assign step_inc = step_reg + step_t'(1);
    assign trial    = {rem_reg, quo_reg[KEY_W-1]};
    assign add_op   = (func_reg == FUNC_ADD) || (func_reg == FUNC_ADD_EXCL);
    assign skip_dup = (func_reg == FUNC_ADD_EXCL) && found_reg;
    assign add_ok   = add_op && !skip_dup && (32'(handle_reg) < 32'(ENTRY_COUNT));

    // Clamp the configured bucket count to 1..NUM_BUCKETS
    always_comb begin
        if (bcount_reg == '0) begin
            clamp = 32'd1;
        end else if (32'(bcount_reg) > 32'(NUM_BUCKETS)) begin
            clamp = 32'(NUM_BUCKETS);
        end else begin
            clamp = 32'(bcount_reg);
        end
    end

    // Address the head RAM with the final remainder so the head is ready in S_HEAD
    cht_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .aclk  (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (bkt_next),
        .rdata (hd_rdata)
    );

    cht_ram #(.WIDTH(SRAM_W), .DEPTH(ENTRY_COUNT)) u_slot_ram (
        .aclk  (aclk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (32'(clr_reg) == 32'(NUM_BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (cnt_reg == cnt_t'(1)) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                state_next = hd_rdata[HEAD_W-1] ? S_WALK : S_UPDATE;
            end
            S_WALK: begin
                if (sl_key == key_reg) begin
                    state_next = S_UPDATE;
                end else if (!sl_link[HEAD_W-1] || 32'(step_inc) >= 32'(ENTRY_COUNT)) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Handshake and RAM control outputs
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
        hd_we     = 1'b0;
        hd_waddr  = bkt_reg;
        hd_wdata  = '0;
        sl_we     = 1'b0;
        sl_waddr  = slot_t'(handle_reg);
        sl_wdata  = {key_reg, head_reg};
        sl_raddr  = cur_reg;
        unique case (state_reg)
            S_CLEAR: begin
                hd_we    = 1'b1;
                hd_waddr = clr_reg;
            end
            S_HEAD: begin
                sl_raddr = hd_rdata[SLOT_W-1:0];
            end
            S_WALK: begin
                sl_raddr = sl_link[SLOT_W-1:0];
            end
            S_UPDATE: begin
                if (add_ok) begin
                    // Prepend the slot to its bucket
                    sl_we    = 1'b1;
                    hd_we    = 1'b1;
                    hd_wdata = {1'b1, slot_t'(handle_reg)};
                end else if (func_reg == FUNC_DELETE && found_reg) begin
                    // Unlink the match from its predecessor or from the head
                    if (pvalid_reg) begin
                        sl_we    = 1'b1;
                        sl_waddr = prev_reg;
                        sl_wdata = {pkey_reg, mnext_reg};
                    end else begin
                        hd_we    = 1'b1;
                        hd_wdata = mnext_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        cnt_next     = cnt_reg;
        bkt_next     = bkt_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        match_next   = match_reg;
        mnext_next   = mnext_reg;
        pvalid_next  = pvalid_reg;
        prev_next    = prev_reg;
        pkey_next    = pkey_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + bkt_t'(1);
            end
            S_IDLE: begin
                quo_next = s_data.key[KEY_W-1:0];
                rem_next = '0;
                div_next = div_t'(clamp);
                cnt_next = cnt_t'(KEY_W);
            end
            S_DIV: begin
                // One restoring remainder step per cycle
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = div_t'(trial - {1'b0, div_reg});
                end else begin
                    rem_next = div_t'(trial);
                end
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg - cnt_t'(1);
                bkt_next = bkt_t'(rem_next);
            end
            S_HEAD: begin
                head_next   = hd_rdata;
                cur_next    = hd_rdata[SLOT_W-1:0];
                step_next   = '0;
                found_next  = 1'b0;
                pvalid_next = 1'b0;
                prev_next   = '0;
                match_next  = '0;
            end
            S_WALK: begin
                if (sl_key == key_reg) begin
                    found_next = 1'b1;
                    match_next = cur_reg;
                    mnext_next = sl_link;
                end else begin
                    pvalid_next = 1'b1;
                    prev_next   = cur_reg;
                    pkey_next   = sl_key;
                    cur_next    = sl_link[SLOT_W-1:0];
                    step_next   = step_inc;
                    if (!sl_link[HEAD_W-1] || 32'(step_inc) >= 32'(ENTRY_COUNT)) begin
                        pvalid_next = 1'b0;
                        prev_next   = '0;
                    end
                end
            end
            S_UPDATE: begin
                if (add_op && !skip_dup) begin
                    res_next.status       = add_ok ? ST_OK : ST_NOT_FOUND;
                    res_next.entry_handle = add_ok ? handle_reg : 8'd0;
                    res_next.prev_valid   = 1'b0;
                    res_next.prev_handle  = 8'd0;
                end else begin
                    if (skip_dup) begin
                        res_next.status = ST_DUPLICATE;
                    end else if (found_reg) begin
                        res_next.status = ST_OK;
                    end else begin
                        res_next.status = ST_NOT_FOUND;
                    end
                    res_next.entry_handle = 8'(match_reg);
                    res_next.prev_valid   = pvalid_reg;
                    res_next.prev_handle  = 8'(prev_reg);
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            bcount_reg  <= BUCKET_COUNT_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                bcount_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg   <= s_data.func;
            key_reg    <= s_data.key[KEY_W-1:0];
            handle_reg <= s_data.handle;
        end
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        bkt_reg    <= bkt_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        step_reg   <= step_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
        mnext_reg  <= mnext_next;
        pvalid_reg <= pvalid_next;
        prev_reg   <= prev_next;
        pkey_reg   <= pkey_next;
        res_reg    <= res_next;
        if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### hw/rtl/cht_checker.sv
// Port-level checker for the chained hash table, bound to the top level.
// Depends on cht_pkg.
`default_nettype none
module cht_checker
    import cht_pkg::*;
(
    input wire             aclk,
    input wire             aresetn,
    input wire             s_valid,
    input wire             s_ready,
    input wire             m_valid,
    input wire             m_ready,
    input rsp_t            m_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Block is busy right after taking a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !$rose(m_valid))
        else $error("request taken while busy");

    // Not-found results carry zero fields
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NOT_FOUND |->
            m_data.entry_handle == 8'd0 && !m_data.prev_valid && m_data.prev_handle == 8'd0)
        else $error("not-found result with nonzero fields");

    // Status code and predecessor consistency
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3 && (m_data.prev_valid || m_data.prev_handle == 8'd0))
        else $error("bad status or predecessor");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for chained_hash_table_top: random and directed
// find/add/add-if-absent/delete transactions checked against an internal table model.
// Depends on cht_pkg and the chained_hash_table_top RTL.
`timescale 1ns / 1ps
module testbench;
    import cht_pkg::*;

    localparam int NB = 256;
    localparam int NE = 256;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    chained_hash_table_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Table shadow state
    logic        head_live [NB];
    logic [7:0]  head_idx [NB];
    logic [31:0] entry_key [NE];
    logic        link_live [NE];
    logic [7:0]  link_idx [NE];
    logic [8:0]  buckets_used;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   cycle_count = 0;
    bit   idle_enable = 1'b1;
    bit   hold_results = 1'b0;
    int   hold_cycles = 0;
    bit   in_taken = 1'b0;

    // Hash-table update and expected result for one request
    function automatic rsp_t table_apply(req_t r);
        rsp_t o;
        int n, b, steps;
        logic live, found, pv;
        logic [7:0] cur, prv, hit;
        n = buckets_used == 0 ? 1 : (buckets_used > NB ? NB : buckets_used);
        b = r.key % n;
        live = head_live[b];
        cur = head_idx[b];
        steps = 0;
        found = 1'b0;
        pv = 1'b0;
        prv = '0;
        hit = '0;
        while (live && steps < NE && !found) begin
            if (entry_key[cur] == r.key) begin
                found = 1'b1;
                hit = cur;
            end else begin
                pv = 1'b1;
                prv = cur;
                live = link_live[cur];
                cur = link_idx[cur];
                steps++;
            end
        end
        if (!found) begin
            pv = 1'b0;
            prv = '0;
        end
        o = '0;
        if (r.func == FUNC_ADD || r.func == FUNC_ADD_EXCL) begin
            if (r.func == FUNC_ADD_EXCL && found) begin
                o.status = ST_DUPLICATE;
                o.entry_handle = hit;
                o.prev_valid = pv;
                o.prev_handle = prv;
            end else begin
                entry_key[r.handle] = r.key;
                link_live[r.handle] = head_live[b];
                link_idx[r.handle] = head_idx[b];
                head_live[b] = 1'b1;
                head_idx[b] = r.handle;
                o.status = ST_OK;
                o.entry_handle = r.handle;
            end
        end else if (!found) begin
            o.status = ST_NOT_FOUND;
        end else begin
            o.status = ST_OK;
            o.entry_handle = hit;
            o.prev_valid = pv;
            o.prev_handle = prv;
            if (r.func == FUNC_DELETE) begin
                if (pv) begin
                    link_live[prv] = link_live[hit];
                    link_idx[prv] = link_idx[hit];
                end else begin
                    head_live[b] = link_live[hit];
                    head_idx[b] = link_idx[hit];
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Driver: present queued requests, advance only after acceptance, idle at random
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_reqs.size() > 0 &&
                    !(idle_enable && $urandom_range(99) < 35)) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Predict on each accepted request and flag the acceptance for the driver
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_rsps.push_back(table_apply(s_data));
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (hold_results) begin
            hold_cycles <= 600;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_enable && $urandom_range(99) < 35);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_rsps.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.entry_handle !== want.entry_handle)
                    report_mismatch("entry_handle", m_data.entry_handle, want.entry_handle);
                if (m_data.prev_valid !== want.prev_valid)
                    report_mismatch("prev_valid", m_data.prev_valid, want.prev_valid);
                if (m_data.prev_handle !== want.prev_handle)
                    report_mismatch("prev_handle", m_data.prev_handle, want.prev_handle);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chained_hash_table_top regression: fail");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_valid && expected_rsps.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_buckets(logic [8:0] n);
        @(negedge aclk);
        cfg_data <= n;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        buckets_used = n;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t make_req(logic [1:0] f, logic [31:0] k, logic [7:0] h);
        req_t r;
        r.func = f;
        r.key = k;
        r.handle = h;
        return r;
    endfunction

    // Random phase: handles drawn at random from 0..255, keys mostly from a 16-entry set
    task automatic random_phase(int count, int key_span);
        logic [31:0] keys [16];
        for (int i = 0; i < 16; i++)
            keys[i] = $urandom_range(key_span);
        keys[15] = 32'hFFFF_FFFF;
        for (int i = 0; i < count; i++) begin
            logic [31:0] k;
            k = ($urandom_range(9) == 0) ? $urandom : keys[$urandom_range(15)];
            pending_reqs.push_back(make_req(2'($urandom_range(3)), k,
                                            8'($urandom_range(255))));
        end
    endtask

    initial begin
        for (int i = 0; i < NB; i++) begin
            head_live[i] = 1'b0;
            head_idx[i] = '0;
        end
        for (int i = 0; i < NE; i++) begin
            entry_key[i] = '0;
            link_live[i] = 1'b0;
            link_idx[i] = '0;
        end
        buckets_used = 9'd256;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every operation, duplicates, head and mid-chain deletes
        write_buckets(9'd4);
        pending_reqs.push_back(make_req(FUNC_FIND, 32'd0, 8'd0));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'd0, 8'd0));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'd4, 8'd255));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'd8, 8'd1));
        pending_reqs.push_back(make_req(FUNC_FIND, 32'd0, 8'd0));
        pending_reqs.push_back(make_req(FUNC_ADD_EXCL, 32'd4, 8'd2));
        pending_reqs.push_back(make_req(FUNC_ADD_EXCL, 32'd12, 8'd2));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'd4, 8'd3));
        pending_reqs.push_back(make_req(FUNC_DELETE, 32'd8, 8'd0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 32'd12, 8'd0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 32'd99, 8'd0));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'hFFFF_FFFF, 8'hAA));
        pending_reqs.push_back(make_req(FUNC_FIND, 32'hFFFF_FFFF, 8'h55));
        pending_reqs.push_back(make_req(FUNC_ADD, 32'd4, 8'd0));
        pending_reqs.push_back(make_req(FUNC_FIND, 32'd0, 8'd0));
        pending_reqs.push_back(make_req(FUNC_DELETE, 32'hFFFF_FFFF, 8'hFF));
        drain();

        // Extremes of the bucket count, including out-of-range values
        write_buckets(9'd0);
        random_phase(40, 64);
        drain();
        write_buckets(9'd511);
        random_phase(40, 1024);
        drain();

        // Fill up while the receiver holds off, then resume
        write_buckets(9'd1);
        hold_results = 1'b1;
        random_phase(20, 32);
        @(posedge aclk);
        @(posedge aclk);
        hold_results = 1'b0;
        drain();

        // Long stretch with no idling
        write_buckets(9'd7);
        idle_enable = 1'b0;
        random_phase(80, 100);
        drain();
        idle_enable = 1'b1;

        write_buckets(9'd256);
        random_phase(120, 2000);
        drain();
        write_buckets(9'd13);
        random_phase(100, 200);
        drain();
        write_buckets(9'd255);
        random_phase(100, 4000);
        drain();

        if (errors == 0) begin
            $display("chained_hash_table_top regression: pass");
        end else begin
            $display("chained_hash_table_top regression: fail");
        end
        $finish;
    end
endmodule
